// File: design/i2cte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target bit engine package
// Shared codes, widths and the result record of the I2C target bit engine.
// ----------------------------------------------------------------------------
package i2cte_pkg;

   localparam int unsigned DRIVE_W = 2;
   localparam int unsigned EVENT_W = 3;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 4;

   localparam logic [DRIVE_W-1:0] DRV_NONE    = 2'd0;
   localparam logic [DRIVE_W-1:0] DRV_RELEASE = 2'd1;
   localparam logic [DRIVE_W-1:0] DRV_LOW     = 2'd2;

   localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_START   = 3'd1;
   localparam logic [EVENT_W-1:0] EV_RESTART = 3'd2;
   localparam logic [EVENT_W-1:0] EV_STOP    = 3'd3;
   localparam logic [EVENT_W-1:0] EV_WRITTEN = 3'd4;
   localparam logic [EVENT_W-1:0] EV_REQUEST = 3'd5;

   localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;
   localparam logic [COUNT_W-1:0] ACK_BITS      = 4'd1;

   typedef struct packed {
      logic [DRIVE_W-1:0] sda_drive;
      logic [EVENT_W-1:0] bus_event;
      logic [BYTE_W-1:0]  event_byte;
   } result_type;

endpackage

// File: design/i2cte_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target bit engine core
// Holds the line history, bus phase, bit counters and shifters, and computes
// the result of one line sample with short combinational logic.
// ----------------------------------------------------------------------------
module i2cte_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 sda_level,
   input  logic                                 scl_level,
   input  logic                                 target_ack,
   input  logic [i2cte_pkg::BYTE_W-1:0]         target_byte,
   output i2cte_pkg::result_type                result
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RX_ADDR,
      PH_RX_BYTE,
      PH_ACK_RX,
      PH_ACK_TX,
      PH_TX_BYTE,
      PH_RX_ACK
   } phase_type;

   logic                                last_sda_ff, last_sda_in;
   logic                                last_scl_ff, last_scl_in;
   phase_type                           phase_ff, phase_in;
   logic [i2cte_pkg::COUNT_W-1:0]       bits_in_ff, bits_in_in;
   logic [i2cte_pkg::COUNT_W-1:0]       bits_out_ff, bits_out_in;
   logic [i2cte_pkg::BYTE_W-1:0]        shift_in_ff, shift_in_in;
   logic [i2cte_pkg::BYTE_W-1:0]        shift_out_ff, shift_out_in;

   logic                                start_seen;
   logic                                stop_seen;
   logic                                scl_rise;
   logic                                scl_fall;
   logic [i2cte_pkg::COUNT_W-1:0]       bits_in_next;
   logic [i2cte_pkg::COUNT_W-1:0]       bits_out_next;
   logic [i2cte_pkg::BYTE_W-1:0]        shift_in_next;

   assign start_seen    = last_sda_ff && !sda_level && last_scl_ff && scl_level;
   assign stop_seen     = !last_sda_ff && sda_level && last_scl_ff && scl_level;
   assign scl_rise      = !last_scl_ff && scl_level;
   assign scl_fall      = last_scl_ff && !scl_level;
   assign bits_in_next  = bits_in_ff + 4'd1;
   assign bits_out_next = bits_out_ff - 4'd1;
   assign shift_in_next = {shift_in_ff[i2cte_pkg::BYTE_W-2:0], sda_level};

   always_comb begin
      last_sda_in       = sda_level;
      last_scl_in       = scl_level;
      phase_in          = phase_ff;
      bits_in_in        = bits_in_ff;
      bits_out_in       = bits_out_ff;
      shift_in_in       = shift_in_ff;
      shift_out_in      = shift_out_ff;
      result.sda_drive  = i2cte_pkg::DRV_NONE;
      result.bus_event  = i2cte_pkg::EV_NONE;
      result.event_byte = '0;

      priority if (start_seen) begin
         result.bus_event = (phase_ff != PH_IDLE) ? i2cte_pkg::EV_RESTART
                                                  : i2cte_pkg::EV_START;
         phase_in    = PH_RX_ADDR;
         bits_in_in  = '0;
         bits_out_in = '0;
      end else if (stop_seen) begin
         result.bus_event = i2cte_pkg::EV_STOP;
         phase_in         = PH_IDLE;
      end else if (scl_rise) begin
         shift_in_in = shift_in_next;
         bits_in_in  = bits_in_next;
         unique case (phase_ff)
            PH_RX_ADDR, PH_RX_BYTE: begin
               if (bits_in_next == i2cte_pkg::BITS_PER_BYTE) begin
                  bits_in_in        = '0;
                  result.bus_event  = i2cte_pkg::EV_WRITTEN;
                  result.event_byte = shift_in_next;
                  if (!target_ack) begin
                     phase_in = PH_IDLE;
                  end else if (phase_ff == PH_RX_ADDR) begin
                     phase_in = shift_in_next[0] ? PH_ACK_TX : PH_ACK_RX;
                  end else begin
                     phase_in = PH_ACK_RX;
                  end
               end
            end
            PH_RX_ACK, PH_ACK_TX: begin
               if (bits_in_next == i2cte_pkg::ACK_BITS) begin
                  bits_in_in       = '0;
                  phase_in         = PH_TX_BYTE;
                  result.bus_event = i2cte_pkg::EV_REQUEST;
                  shift_out_in     = target_byte;
                  bits_out_in      = i2cte_pkg::BITS_PER_BYTE;
               end
            end
            PH_ACK_RX: begin
               if (bits_in_next == i2cte_pkg::ACK_BITS) begin
                  bits_in_in = '0;
                  phase_in   = PH_RX_BYTE;
               end
            end
            default: begin
            end
         endcase
      end else if (scl_fall) begin
         unique case (phase_ff)
            PH_IDLE, PH_RX_ADDR: begin
               result.sda_drive = i2cte_pkg::DRV_RELEASE;
            end
            PH_ACK_TX, PH_ACK_RX: begin
               result.sda_drive = i2cte_pkg::DRV_LOW;
            end
            PH_TX_BYTE: begin
               result.sda_drive = shift_out_ff[i2cte_pkg::BYTE_W-1]
                                  ? i2cte_pkg::DRV_RELEASE : i2cte_pkg::DRV_LOW;
               shift_out_in = {shift_out_ff[i2cte_pkg::BYTE_W-2:0], 1'b0};
               bits_out_in  = bits_out_next;
               if (bits_out_next == '0) begin
                  phase_in = PH_RX_ACK;
               end
            end
            default: begin
            end
         endcase
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sda_ff  <= 1'b1;
         last_scl_ff  <= 1'b1;
         phase_ff     <= PH_IDLE;
         bits_in_ff   <= '0;
         bits_out_ff  <= '0;
         shift_in_ff  <= '0;
         shift_out_ff <= '0;
      end else if (accept) begin
         last_sda_ff  <= last_sda_in;
         last_scl_ff  <= last_scl_in;
         phase_ff     <= phase_in;
         bits_in_ff   <= bits_in_in;
         bits_out_ff  <= bits_out_in;
         shift_in_ff  <= shift_in_in;
         shift_out_ff <= shift_out_in;
      end
   end

   // A start or restart always leaves the engine receiving an address.
   assert property (@(posedge clock) disable iff (reset)
      accept && (result.bus_event == i2cte_pkg::EV_START ||
                 result.bus_event == i2cte_pkg::EV_RESTART)
      |=> phase_ff == PH_RX_ADDR && bits_in_ff == '0)
      else $error("start did not enter address phase");

   // A stop always returns the engine to idle.
   assert property (@(posedge clock) disable iff (reset)
      accept && result.bus_event == i2cte_pkg::EV_STOP |=> phase_ff == PH_IDLE)
      else $error("stop did not return to idle");

   // SDA is only ever driven on a falling SCL edge.
   assert property (@(posedge clock) disable iff (reset)
      result.sda_drive != i2cte_pkg::DRV_NONE |-> last_scl_ff && !scl_level)
      else $error("SDA drive outside a falling SCL edge");

   // The outgoing bit counter never exceeds one byte.
   assert property (@(posedge clock) disable iff (reset)
      bits_out_ff <= i2cte_pkg::BITS_PER_BYTE)
      else $error("outgoing bit counter overran");

   // Only written-byte events carry a byte.
   assert property (@(posedge clock) disable iff (reset)
      result.event_byte != '0 |-> result.bus_event == i2cte_pkg::EV_WRITTEN)
      else $error("event byte set on a non-write event");

endmodule

// File: design/i2c_target_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target bit engine
// Bit-level I2C target controller: turns line samples into SDA drive
// commands and bus events.
// ----------------------------------------------------------------------------
// Each request on the req_ channel is one sample of the SDA and SCL lines
// together with the attached targets' acknowledge bit and read byte. Each
// request yields exactly one response on the rsp_ channel: an SDA drive
// command, a bus event and, for written bytes, the received byte.
// The line state is updated in the cycle a request is accepted; the response
// goes to the output register, or to the skid register if the output register
// still waits. While the skid register is empty a new request can be accepted
// every cycle, so the engine follows one sample per clock. When the receiver
// stalls, one further response is parked in the skid register; req_ready then
// falls until it has drained, and requests are never lost or repeated.
// Reset returns the engine to idle with both lines seen high, clears the
// counters and shifters, and empties the output and skid registers.
// ----------------------------------------------------------------------------
module i2c_target_bit_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_sda_level,
   input  logic                                 req_scl_level,
   input  logic                                 req_target_ack,
   input  logic [i2cte_pkg::BYTE_W-1:0]         req_target_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [i2cte_pkg::DRIVE_W-1:0]        rsp_sda_drive,
   output logic [i2cte_pkg::EVENT_W-1:0]        rsp_bus_event,
   output logic [i2cte_pkg::BYTE_W-1:0]         rsp_event_byte
);

   logic                    accept;
   logic                    out_take;
   i2cte_pkg::result_type   result;
   i2cte_pkg::result_type   out_ff;
   i2cte_pkg::result_type   skid_ff;
   logic                    out_valid_ff;
   logic                    skid_valid_ff;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_take  = out_valid_ff && rsp_ready;

   i2cte_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .sda_level   (req_sda_level),
      .scl_level   (req_scl_level),
      .target_ack  (req_target_ack),
      .target_byte (req_target_byte),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sda_drive  = out_ff.sda_drive;
   assign rsp_bus_event  = out_ff.bus_event;
   assign rsp_event_byte = out_ff.event_byte;

   // The skid register only fills behind a waiting output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // A waiting response holds still until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_ff))
      else $error("response changed while stalled");

   // Every accepted request leaves a response waiting.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target bit engine testbench
// Feeds line samples to the engine as well-formed bus transfers (start,
// address, data, acknowledge slots, restart and stop) mixed with broken
// transfers and random line noise. Random gaps and stalls on both channels.
// A scoreboard predicts every response from its own copy of the bus state
// and compares the responses field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned TARGET_ITEMS  = 850;
   localparam int unsigned DRAIN_CYCLES  = 8;

   typedef logic [i2cte_pkg::BYTE_W-1:0] byte_type;

   class bus_scoreboard;
      typedef enum logic [2:0] {
         PH_IDLE    = 3'd0,
         PH_RX_ADDR = 3'd1,
         PH_RX_BYTE = 3'd2,
         PH_ACK_RX  = 3'd3,
         PH_ACK_TX  = 3'd4,
         PH_TX_BYTE = 3'd5,
         PH_RX_ACK  = 3'd6
      } phase_type;

      bit                            prev_sda;
      bit                            prev_scl;
      phase_type                     phase;
      logic [i2cte_pkg::COUNT_W-1:0] rise_count;
      logic [i2cte_pkg::COUNT_W-1:0] drive_count;
      logic [i2cte_pkg::BYTE_W-1:0]  rx_shift;
      logic [i2cte_pkg::BYTE_W-1:0]  tx_shift;
      i2cte_pkg::result_type         pending_results[$];
      int                            error_count;

      function new();
         prev_sda    = 1'b1;
         prev_scl    = 1'b1;
         phase       = PH_IDLE;
         rise_count  = '0;
         drive_count = '0;
         rx_shift    = '0;
         tx_shift    = '0;
         error_count = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
         error_count++;
      endtask

      function void note_sample(bit sda, bit scl, bit ack,
                                logic [i2cte_pkg::BYTE_W-1:0] tbyte);
         i2cte_pkg::result_type r;
         r.sda_drive  = i2cte_pkg::DRV_NONE;
         r.bus_event  = i2cte_pkg::EV_NONE;
         r.event_byte = '0;
         if (prev_sda && !sda && prev_scl && scl) begin
            r.bus_event = (phase != PH_IDLE) ? i2cte_pkg::EV_RESTART : i2cte_pkg::EV_START;
            phase       = PH_RX_ADDR;
            rise_count  = '0;
            drive_count = '0;
         end else if (!prev_sda && sda && prev_scl && scl) begin
            r.bus_event = i2cte_pkg::EV_STOP;
            phase       = PH_IDLE;
         end else if (!prev_scl && scl) begin
            rx_shift   = {rx_shift[i2cte_pkg::BYTE_W-2:0], sda};
            rise_count = rise_count + 1'b1;
            case (phase)
               PH_RX_ADDR, PH_RX_BYTE: begin
                  if (rise_count == i2cte_pkg::BITS_PER_BYTE) begin
                     rise_count   = '0;
                     r.bus_event  = i2cte_pkg::EV_WRITTEN;
                     r.event_byte = rx_shift;
                     if (!ack)
                        phase = PH_IDLE;
                     else if (phase == PH_RX_ADDR)
                        phase = rx_shift[0] ? PH_ACK_TX : PH_ACK_RX;
                     else
                        phase = PH_ACK_RX;
                  end
               end
               PH_RX_ACK, PH_ACK_TX: begin
                  if (rise_count == i2cte_pkg::ACK_BITS) begin
                     rise_count  = '0;
                     phase       = PH_TX_BYTE;
                     r.bus_event = i2cte_pkg::EV_REQUEST;
                     tx_shift    = tbyte;
                     drive_count = i2cte_pkg::BITS_PER_BYTE;
                  end
               end
               PH_ACK_RX: begin
                  if (rise_count == i2cte_pkg::ACK_BITS) begin
                     rise_count = '0;
                     phase      = PH_RX_BYTE;
                  end
               end
               default: begin
               end
            endcase
         end else if (prev_scl && !scl) begin
            case (phase)
               PH_IDLE, PH_RX_ADDR: r.sda_drive = i2cte_pkg::DRV_RELEASE;
               PH_ACK_TX, PH_ACK_RX: r.sda_drive = i2cte_pkg::DRV_LOW;
               PH_TX_BYTE: begin
                  r.sda_drive = tx_shift[i2cte_pkg::BYTE_W-1] ? i2cte_pkg::DRV_RELEASE
                                                               : i2cte_pkg::DRV_LOW;
                  tx_shift    = {tx_shift[i2cte_pkg::BYTE_W-2:0], 1'b0};
                  drive_count = drive_count - 1'b1;
                  if (drive_count == '0)
                     phase = PH_RX_ACK;
               end
               default: begin
               end
            endcase
         end
         prev_sda = sda;
         prev_scl = scl;
         pending_results.push_back(r);
      endfunction

      task check_response(logic [i2cte_pkg::DRIVE_W-1:0] drive,
                          logic [i2cte_pkg::EVENT_W-1:0] ev,
                          logic [i2cte_pkg::BYTE_W-1:0] evb);
         i2cte_pkg::result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response, event", ev, -1);
         end else begin
            want = pending_results.pop_front();
            if (drive !== want.sda_drive)
               report_mismatch("sda_drive", drive, want.sda_drive);
            if (ev !== want.bus_event)
               report_mismatch("bus_event", ev, want.bus_event);
            if (evb !== want.event_byte)
               report_mismatch("event_byte", evb, want.event_byte);
         end
      endtask
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_sda_level;
   logic                           req_scl_level;
   logic                           req_target_ack;
   logic [i2cte_pkg::BYTE_W-1:0]   req_target_byte;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b1;
   logic [i2cte_pkg::DRIVE_W-1:0]  rsp_sda_drive;
   logic [i2cte_pkg::EVENT_W-1:0]  rsp_bus_event;
   logic [i2cte_pkg::BYTE_W-1:0]   rsp_event_byte;

   bus_scoreboard sb;
   bit            quiet;
   int unsigned   stall_left = 0;
   int unsigned   cycle_count = 0;
   int unsigned   items_sent;
   bit            line_sda;
   bit            line_scl;

   i2c_target_bit_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sda_level   (req_sda_level),
      .req_scl_level   (req_scl_level),
      .req_target_ack  (req_target_ack),
      .req_target_byte (req_target_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sda_drive   (rsp_sda_drive),
      .rsp_bus_event   (rsp_bus_event),
      .rsp_event_byte  (rsp_event_byte)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int unsigned pick_gap();
      if ($urandom_range(99) < 88)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < 20) begin
         rsp_ready  <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_sample(req_sda_level, req_scl_level, req_target_ack, req_target_byte);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_sda_drive, rsp_bus_event, rsp_event_byte);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic put_sample(bit sda, bit scl, bit ack, byte_type tbyte);
      int unsigned gap;
      gap = 0;
      if (!quiet && $urandom_range(99) < 25)
         gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_sda_level   <= sda;
      req_scl_level   <= scl;
      req_target_ack  <= ack;
      req_target_byte <= tbyte;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
      line_sda = sda;
      line_scl = scl;
   endtask

   task automatic drive_lines(bit sda, bit scl);
      int unsigned reps;
      reps = ($urandom_range(99) < 75) ? 1 : $urandom_range(3, 2);
      repeat (reps)
         put_sample(sda, scl, $urandom_range(99) < 85, byte_type'($urandom_range(255)));
   endtask

   task automatic bus_start();
      drive_lines(line_sda, 1'b0);
      drive_lines(1'b1, 1'b0);
      drive_lines(1'b1, 1'b1);
      drive_lines(1'b0, 1'b1);
      drive_lines(1'b0, 1'b0);
   endtask

   task automatic bus_stop();
      drive_lines(line_sda, 1'b0);
      drive_lines(1'b0, 1'b0);
      drive_lines(1'b0, 1'b1);
      drive_lines(1'b1, 1'b1);
   endtask

   task automatic bus_bit(bit b);
      drive_lines(b, 1'b0);
      drive_lines(b, 1'b1);
      drive_lines(b, 1'b0);
   endtask

   task automatic bus_byte(byte_type b);
      for (int i = i2cte_pkg::BYTE_W - 1; i >= 0; i--)
         bus_bit(b[i]);
   endtask

   task automatic run_transfer(bit complete);
      byte_type    addr;
      int unsigned nbytes;
      int unsigned extra;
      addr   = byte_type'($urandom_range(255));
      nbytes = $urandom_range(3, 1);
      extra  = addr[0] ? $urandom_range(8, 0) : 0;
      bus_start();
      bus_byte(addr);
      bus_bit(1'($urandom_range(1)));
      if (!complete) begin
         repeat ($urandom_range(12, 1)) bus_bit(1'($urandom_range(1)));
      end else begin
         repeat (nbytes) begin
            bus_byte(byte_type'($urandom_range(255)));
            bus_bit(1'($urandom_range(1)));
         end
         repeat (extra) bus_bit(1'($urandom_range(1)));
      end
      if ($urandom_range(3) != 0)
         bus_stop();
   endtask

   initial begin
      int unsigned pick;
      bit          pressure_done;
      sb              = new();
      quiet           = 1'b0;
      pressure_done   = 1'b0;
      items_sent      = 0;
      line_sda        = 1'b1;
      line_scl        = 1'b1;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sda_level   = 1'b1;
      req_scl_level   = 1'b1;
      req_target_ack  = 1'b0;
      req_target_byte = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      put_sample(1'b1, 1'b1, 1'b0, 8'h00);
      put_sample(1'b1, 1'b0, 1'b1, 8'hFF);
      put_sample(1'b0, 1'b0, 1'b0, 8'h00);
      put_sample(1'b0, 1'b1, 1'b1, 8'hFF);
      put_sample(1'b1, 1'b1, 1'b0, 8'h00);
      put_sample(1'b0, 1'b1, 1'b1, 8'hFF);
      put_sample(1'b0, 1'b0, 1'b0, 8'h00);
      put_sample(1'b1, 1'b0, 1'b1, 8'hFF);
      put_sample(1'b1, 1'b1, 1'b0, 8'h00);
      put_sample(1'b0, 1'b1, 1'b1, 8'hFF);
      put_sample(1'b1, 1'b1, 1'b0, 8'h00);
      put_sample(1'b0, 1'b0, 1'b1, 8'hFF);
      put_sample(1'b1, 1'b1, 1'b0, 8'h00);
      put_sample(1'b0, 1'b1, 1'b1, 8'hFF);
      put_sample(1'b1, 1'b0, 1'b0, 8'h00);
      put_sample(1'b0, 1'b1, 1'b1, 8'hFF);

      while (items_sent < TARGET_ITEMS) begin
         quiet = ($urandom_range(99) < 15);
         pick  = $urandom_range(99);
         if (pick < 70)
            run_transfer(1'b1);
         else if (pick < 85)
            run_transfer(1'b0);
         else
            repeat ($urandom_range(20, 4))
               put_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), byte_type'($urandom_range(255)));
         if (!pressure_done && items_sent > TARGET_ITEMS / 2) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
            pressure_done = 1'b1;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      quiet = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
design/i2cte_pkg.sv
design/i2cte_core.sv
design/i2c_target_bit_engine.sv
bench/tb_top.sv
